@@ hdl/weighted_particle_mean_covariance_top_macros.svh @@
// Assertion helpers for the particle statistics block.
`ifndef WEIGHTED_PARTICLE_MEAN_COVARIANCE_TOP_MACROS_SVH
`define WEIGHTED_PARTICLE_MEAN_COVARIANCE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WPMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpmc same-cycle check failed");
`define WPMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpmc next-cycle check failed");
`else
`define WPMC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define WPMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/wpmc_pkg.sv @@
package wpmc_pkg;
   localparam int PARTICLE_MAX = 1024;
   localparam int ADDR_W = $clog2(PARTICLE_MAX);
   localparam int COUNT_W = ADDR_W + 1;
   localparam int STATE_DIM = 4;
   localparam int WC_W = 17;
   localparam int MEM_W = WC_W + 16 * STATE_DIM;
   localparam int NUM_W = 72;
   localparam int DEN_W = 43;
   localparam int STEP_W = 7;
   localparam logic [STEP_W-1:0] NORM_STEPS = 7'd48;
   localparam logic [STEP_W-1:0] COV_STEPS = 7'd72;

   typedef struct packed {
      logic start;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;
endpackage

@@ hdl/wpmc_div.sv @@
module wpmc_div
   import wpmc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  div_req_type req,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_sts_type sts,
   output logic [NUM_W-1:0] quot
);
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in, quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0] shifted, diff;
   logic ge;

   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      diff = shifted - {1'b0, den_ff};
      ge = shifted >= {1'b0, den_ff};
      cnt_in = cnt_ff;
      num_in = num_ff;
      quot_in = quot_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         cnt_in = req.steps;
         num_in = num;
         den_in = den;
         rem_in = '0;
         quot_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], ge};
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      quot_ff <= quot_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot = quot_ff;
endmodule

@@ hdl/weighted_particle_mean_covariance_top.sv @@
// Weighted particle mean and covariance. Particles are loaded one per cycle into an
// on-chip store of 1024 entries until the transfer marked last; the block then walks the
// store once for the means (with a normalizing division per particle when normalizing)
// and once more for every covariance entry (one read port and the multiplier chain per
// particle, then a shift-subtract divide unless the divisor is zero). Both walks are
// skipped when normalizing a zero weight total. Results appear one at a time on the rsp
// channel: the D means, then the row-major upper triangle; the next set is accepted after
// the transfer that carries end_of_run. Stored data need no clearing after reset.
`include "weighted_particle_mean_covariance_top_macros.svh"

module weighted_particle_mean_covariance_top
   import wpmc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [15:0] req_weight,
   input  logic signed [15:0] req_state_0,
   input  logic signed [15:0] req_state_1,
   input  logic signed [15:0] req_state_2,
   input  logic signed [15:0] req_state_3,
   input  logic req_last,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_row,
   output logic [1:0] rsp_col,
   output logic rsp_is_mean,
   output logic signed [31:0] rsp_value,
   output logic rsp_degenerate,
   output logic rsp_end_of_run,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam logic [4:0] S_LOAD = 5'd0, S_MRD = 5'd1, S_MGOT = 5'd2, S_MDIVW = 5'd3,
      S_MWC = 5'd4, S_MMUL = 5'd5, S_MACC = 5'd6, S_MSQ = 5'd7, S_MFIN = 5'd8,
      S_MOUT = 5'd9, S_MNEXT = 5'd10, S_CSTART = 5'd11, S_CRD = 5'd12, S_CDEV = 5'd13,
      S_CMUL1 = 5'd14, S_CMUL2 = 5'd15, S_CACC = 5'd16, S_CDIV = 5'd17,
      S_CDIVW = 5'd18, S_CNEXT = 5'd19, S_WAIT = 5'd20;
   localparam logic REG_NORMALIZE = 1'b0;
   localparam logic REG_DIMS = 1'b1;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   logic [MEM_W-1:0] mem [PARTICLE_MAX];
   logic [MEM_W-1:0] mem_rd_ff;
   logic mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [MEM_W-1:0] mem_wdata;

   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [26:0] total_ff, total_in;
   logic norm_ff, norm_in;
   logic [2:0] dims_ff, dims_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [1:0] lane_ff, lane_in, j_ff, j_in, k_ff, k_in;
   logic zsum_ff, zsum_in, zdiv_ff, zdiv_in, neg_ff, neg_in;
   logic [32:0] wn_ff, wn_in;
   logic [WC_W-1:0] wc_ff, wc_in;
   logic signed [49:0] prod_ff, prod_in, p1_ff, p1_in;
   logic signed [59:0] p2_ff, p2_in;
   logic signed [63:0] macc_ff [STATE_DIM];
   logic signed [63:0] macc_in [STATE_DIM];
   logic signed [63:0] acc_ff, acc_in;
   logic [42:0] sumsq_ff, sumsq_in;
   logic [42:0] dabs_ff, dabs_in;
   logic dneg_ff, dneg_in;
   logic signed [24:0] dj_ff, dj_in, dk_ff, dk_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_mean_ff, rsp_mean_in;
   logic rsp_degen_ff, rsp_degen_in, rsp_end_ff, rsp_end_in;
   logic [1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;

   div_req_type div_req;
   div_sts_type div_sts;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [DEN_W-1:0] div_den;

   logic signed [63:0] rnd [STATE_DIM];
   logic signed [39:0] rfull [STATE_DIM];
   logic signed [23:0] ctr [STATE_DIM];
   logic [1:0] last_dim;
   logic req_fire, store, cfg_write;
   logic [26:0] total_next;
   logic emit, e_mean, e_end;
   logic signed [31:0] e_val;
   logic signed [39:0] rsel;
   logic signed [15:0] comp_a, comp_b;
   logic [33:0] wc_sum;
   logic signed [64:0] sum65;
   logic signed [43:0] div_w;
   logic [63:0] ua;
   logic [31:0] mag;
   logic run_done;

   wpmc_div u_div (
      .clock(clock), .reset(reset), .req(div_req), .num(div_num), .den(div_den),
      .sts(div_sts), .quot(div_quot)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      for (int l = 0; l < STATE_DIM; l++) begin
         rnd[l] = macc_ff[l] + 64'sd8388608;
         rfull[l] = rnd[l][63:24];
         if (rfull[l] > 40'sd8388607) begin
            ctr[l] = 24'sh7F_FFFF;
         end else if (rfull[l] < -40'sd8388608) begin
            ctr[l] = 24'sh80_0000;
         end else begin
            ctr[l] = rfull[l][23:0];
         end
      end
   end

   assign cfg_write = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_DIMS) ? {29'd0, dims_ff} : {31'd0, norm_ff};
   assign last_dim = (dims_ff == 3'd0) ? 2'd0 : (dims_ff >= 3'd4) ? 2'd3 : 2'(dims_ff - 3'd1);
   assign req_ready = (state_ff == S_LOAD);
   assign req_fire = req_valid && req_ready;
   assign store = count_ff < COUNT_W'(PARTICLE_MAX);
   assign total_next = total_ff + (store ? {11'd0, req_weight} : 27'd0);

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      count_in = count_ff;
      total_in = total_ff;
      norm_in = norm_ff;
      dims_in = dims_ff;
      idx_in = idx_ff;
      lane_in = lane_ff;
      j_in = j_ff;
      k_in = k_ff;
      zsum_in = zsum_ff;
      zdiv_in = zdiv_ff;
      neg_in = neg_ff;
      wn_in = wn_ff;
      wc_in = wc_ff;
      prod_in = prod_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      macc_in = macc_ff;
      acc_in = acc_ff;
      sumsq_in = sumsq_ff;
      dabs_in = dabs_ff;
      dneg_in = dneg_ff;
      dj_in = dj_ff;
      dk_in = dk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_end_in = rsp_end_ff;
      rsp_row_in = rsp_row_ff;
      rsp_col_in = rsp_col_ff;
      rsp_val_in = rsp_val_ff;
      mem_we = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = {wc_ff, mem_rd_ff[16*STATE_DIM-1:0]};
      mem_re = 1'b0;
      mem_raddr = idx_ff;
      div_req.start = 1'b0;
      div_req.steps = NORM_STEPS;
      div_num = {mem_rd_ff[16*STATE_DIM +: 16], 56'd0};
      div_den = {16'd0, total_ff};
      emit = 1'b0;
      e_mean = 1'b0;
      e_end = 1'b0;
      e_val = VAL_MAX;
      rsel = rfull[j_ff];
      comp_a = mem_rd_ff[16*lane_ff +: 16];
      comp_b = mem_rd_ff[16*k_ff +: 16];
      wc_sum = {1'b0, wn_ff} + 34'd32768;
      sum65 = {acc_ff[63], acc_ff} + {{5{p2_ff[59]}}, p2_ff};
      div_w = 44'sh1_0000_0000 - $signed({1'b0, sumsq_ff});
      ua = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
      mag = div_quot[31:0];

      if (cfg_write) begin
         if (paddr[2] == REG_NORMALIZE) begin
            norm_in = pwdata[0];
         end else begin
            dims_in = pwdata[2:0];
         end
      end

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (store) begin
                  mem_we = 1'b1;
                  mem_waddr = count_ff[ADDR_W-1:0];
                  mem_wdata = {1'b0, req_weight, req_state_3, req_state_2, req_state_1,
                     req_state_0};
                  count_in = count_ff + 1'b1;
                  total_in = total_next;
               end
               if (req_last) begin
                  zsum_in = norm_ff && (total_next == 27'd0);
                  zdiv_in = 1'b0;
                  for (int l = 0; l < STATE_DIM; l++) begin
                     macc_in[l] = '0;
                  end
                  sumsq_in = '0;
                  idx_in = '0;
                  j_in = 2'd0;
                  k_in = 2'd0;
                  state_in = (norm_ff && (total_next == 27'd0)) ? S_MOUT : S_MRD;
               end
            end
         end
         S_MRD: begin
            mem_re = 1'b1;
            state_in = S_MGOT;
         end
         S_MGOT: begin
            if (norm_ff) begin
               div_req.start = 1'b1;
               state_in = S_MDIVW;
            end else begin
               wn_in = {1'b0, mem_rd_ff[16*STATE_DIM +: 16], 16'd0};
               state_in = S_MWC;
            end
         end
         S_MDIVW: begin
            if (div_sts.done) begin
               wn_in = div_quot[32:0];
               state_in = S_MWC;
            end
         end
         S_MWC: begin
            wc_in = wc_sum[32:16];
            lane_in = 2'd0;
            state_in = S_MMUL;
         end
         S_MMUL: begin
            prod_in = $signed({1'b0, wn_ff}) * comp_a;
            state_in = S_MACC;
         end
         S_MACC: begin
            macc_in[lane_ff] = macc_ff[lane_ff] + {{14{prod_ff[49]}}, prod_ff};
            lane_in = lane_ff + 1'b1;
            state_in = (lane_ff == 2'(STATE_DIM - 1)) ? S_MSQ : S_MMUL;
         end
         S_MSQ: begin
            // Keep the rounded weight in the store for the covariance walks.
            mem_we = 1'b1;
            sumsq_in = sumsq_ff + 43'(wc_ff) * 43'(wc_ff);
            if (idx_ff == ADDR_W'(count_ff - 1'b1)) begin
               state_in = S_MFIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         S_MFIN: begin
            zdiv_in = (div_w == 44'sd0);
            dneg_in = div_w[43];
            dabs_in = div_w[43] ? 43'(-div_w) : div_w[42:0];
            j_in = 2'd0;
            state_in = S_MOUT;
         end
         S_MOUT: begin
            emit = 1'b1;
            e_mean = 1'b1;
            if (zsum_ff || rsel > 40'sh7FFF_FFFF) begin
               e_val = VAL_MAX;
            end else if (rsel < -40'sh8000_0000) begin
               e_val = VAL_MIN;
            end else begin
               e_val = rsel[31:0];
            end
            ret_in = S_MNEXT;
         end
         S_MNEXT: begin
            if (j_ff == last_dim) begin
               j_in = 2'd0;
               k_in = 2'd0;
               state_in = S_CSTART;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_MOUT;
            end
         end
         S_CSTART: begin
            if (zsum_ff) begin
               emit = 1'b1;
               e_val = VAL_MAX;
               e_end = (j_ff == last_dim) && (k_ff == last_dim);
               ret_in = S_CNEXT;
            end else begin
               acc_in = '0;
               idx_in = '0;
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            mem_re = 1'b1;
            state_in = S_CDEV;
         end
         S_CDEV: begin
            comp_a = mem_rd_ff[16*j_ff +: 16];
            dj_in = $signed({comp_a, 8'd0}) - $signed({ctr[j_ff][23], ctr[j_ff]});
            dk_in = $signed({comp_b, 8'd0}) - $signed({ctr[k_ff][23], ctr[k_ff]});
            state_in = S_CMUL1;
         end
         S_CMUL1: begin
            p1_in = dj_ff * dk_ff;
            state_in = S_CMUL2;
         end
         S_CMUL2: begin
            p2_in = $signed(p1_ff[49:8]) * $signed({1'b0, mem_rd_ff[MEM_W-1 -: WC_W]});
            state_in = S_CACC;
         end
         S_CACC: begin
            if (sum65[64] != sum65[63]) begin
               acc_in = sum65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            end else begin
               acc_in = sum65[63:0];
            end
            if (idx_ff == ADDR_W'(count_ff - 1'b1)) begin
               state_in = S_CDIV;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         S_CDIV: begin
            if (zdiv_ff) begin
               emit = 1'b1;
               e_val = acc_ff[63] ? VAL_MIN : VAL_MAX;
               e_end = (j_ff == last_dim) && (k_ff == last_dim);
               ret_in = S_CNEXT;
            end else begin
               div_req.start = 1'b1;
               div_req.steps = COV_STEPS;
               div_num = {ua, 8'd0};
               div_den = dabs_ff;
               neg_in = acc_ff[63] ^ dneg_ff;
               state_in = S_CDIVW;
            end
         end
         S_CDIVW: begin
            if (div_sts.done) begin
               emit = 1'b1;
               e_end = (j_ff == last_dim) && (k_ff == last_dim);
               ret_in = S_CNEXT;
               if (|div_quot[NUM_W-1:32]) begin
                  e_val = neg_ff ? VAL_MIN : VAL_MAX;
               end else if (neg_ff) begin
                  e_val = (mag > 32'h8000_0000) ? VAL_MIN : $signed(-mag);
               end else begin
                  e_val = mag[31] ? VAL_MAX : $signed(mag);
               end
            end
         end
         S_CNEXT: begin
            if (k_ff == last_dim) begin
               if (j_ff == last_dim) begin
                  count_in = '0;
                  total_in = '0;
                  state_in = S_LOAD;
               end else begin
                  j_in = j_ff + 1'b1;
                  k_in = j_ff + 1'b1;
                  state_in = S_CSTART;
               end
            end else begin
               k_in = k_ff + 1'b1;
               state_in = S_CSTART;
            end
         end
         S_WAIT: begin
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_mean_in = e_mean;
         rsp_val_in = e_val;
         rsp_end_in = e_end;
         rsp_row_in = j_ff;
         rsp_col_in = e_mean ? 2'd0 : k_ff;
         rsp_degen_in = zsum_ff || zdiv_ff;
         state_in = S_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ret_ff <= S_LOAD;
         count_ff <= '0;
         total_ff <= '0;
         norm_ff <= 1'b1;
         dims_ff <= 3'd4;
         rsp_valid_ff <= 1'b0;
         zsum_ff <= 1'b0;
         zdiv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         count_ff <= count_in;
         total_ff <= total_in;
         norm_ff <= norm_in;
         dims_ff <= dims_in;
         rsp_valid_ff <= rsp_valid_in;
         zsum_ff <= zsum_in;
         zdiv_ff <= zdiv_in;
      end
      idx_ff <= idx_in;
      lane_ff <= lane_in;
      j_ff <= j_in;
      k_ff <= k_in;
      neg_ff <= neg_in;
      wn_ff <= wn_in;
      wc_ff <= wc_in;
      prod_ff <= prod_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      macc_ff <= macc_in;
      acc_ff <= acc_in;
      sumsq_ff <= sumsq_in;
      dabs_ff <= dabs_in;
      dneg_ff <= dneg_in;
      dj_ff <= dj_in;
      dk_ff <= dk_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_end_ff <= rsp_end_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row = rsp_row_ff;
   assign rsp_col = rsp_col_ff;
   assign rsp_is_mean = rsp_mean_ff;
   assign rsp_value = rsp_val_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_end_of_run = rsp_end_ff;

   // The last covariance step of a set hands control back to loading.
   assign run_done = (state_ff == S_CNEXT) && (j_ff == last_dim) && (k_ff == last_dim);

   `WPMC_ASSERT_IMPLY(a_load_no_result, clock, reset, req_ready, !rsp_valid)
   `WPMC_ASSERT_NEXT(a_end_returns_to_load, clock, reset, run_done, req_ready)
   `WPMC_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_req.start, !div_sts.busy)
endmodule

@@ test/testbench.sv @@
module testbench;
   localparam logic [2:0] ADDR_NORMALIZE = 3'd0;
   localparam logic [2:0] ADDR_DIMS = 3'd4;
   localparam int STORE_DEPTH = 1024;

   typedef struct {
      logic [15:0] weight;
      logic signed [15:0] state [4];
      logic last;
   } particle_type;

   typedef struct {
      logic [1:0] row;
      logic [1:0] col;
      logic is_mean;
      logic [31:0] value;
      logic degenerate;
      logic end_of_run;
   } stat_entry_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_weight = '0;
   logic signed [15:0] req_state_0 = '0;
   logic signed [15:0] req_state_1 = '0;
   logic signed [15:0] req_state_2 = '0;
   logic signed [15:0] req_state_3 = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_row;
   logic [1:0] rsp_col;
   logic rsp_is_mean;
   logic signed [31:0] rsp_value;
   logic rsp_degenerate;
   logic rsp_end_of_run;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   weighted_particle_mean_covariance_top u_top (.*);

   // Predictor state.
   logic [15:0] weight_mem [STORE_DEPTH];
   logic signed [15:0] vector_mem [STORE_DEPTH][4];
   int unsigned stored_count = 0;
   longint unsigned model_weight_total = 0;
   logic normalize_cfg = 1'b1;
   logic [2:0] dims_cfg = 3'd4;

   particle_type pending_particles [$];
   stat_entry_type stats_expected [$];
   particle_type current;
   int error_count = 0;
   int sets_done = 0;
   int results_checked = 0;
   int particles_sent = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_cycle = 0;
   int stall_mode = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("timeout with %0d results still expected", stats_expected.size());
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic longint add_saturated(input longint a, input longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return 64'sh7FFFFFFFFFFFFFFF;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
      return s;
   endfunction

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint divide_covariance(input longint acc, input longint div);
      logic neg;
      logic [63:0] ua, ud, q, r, mag;
      neg = (acc < 0) != (div < 0);
      ua = acc < 0 ? 64'd0 - acc : acc;
      ud = div < 0 ? 64'd0 - div : div;
      q = ua / ud;
      r = ua % ud;
      if (q >= 64'd1 << 24) return neg ? -64'sd2147483648 : 64'sd2147483647;
      mag = q * 256 + (r * 256) / ud;
      return clip32(neg ? -longint'(mag) : longint'(mag));
   endfunction

   function automatic logic [63:0] scaled_weight(input logic [15:0] w);
      if (normalize_cfg) return (64'(w) << 32) / model_weight_total;
      return 64'(w) << 16;
   endfunction

   function automatic void push_entry(input int row, input int col, input logic mean,
                                      input longint value, input logic degen,
                                      input logic fin);
      stat_entry_type e;
      e.row = row[1:0];
      e.col = col[1:0];
      e.is_mean = mean;
      e.value = value[31:0];
      e.degenerate = degen;
      e.end_of_run = fin;
      stats_expected.push_back(e);
   endfunction

   // Mean and covariance of the stored set, in the block's fixed-point steps.
   function automatic void compute_set_statistics();
      int dims, total, n;
      logic zero_sum, zero_div;
      longint mean_acc [4], centre [4], rounded, divisor, acc, dj, dk, v;
      logic [63:0] wn, wc, sumsq;
      dims = dims_cfg;
      if (dims < 1) dims = 1;
      if (dims > 4) dims = 4;
      total = dims + dims * (dims + 1) / 2;
      zero_sum = normalize_cfg && model_weight_total == 0;
      n = 0;
      sets_done++;
      if (zero_sum) begin
         for (int j = 0; j < dims; j++, n++)
            push_entry(j, 0, 1'b1, 64'sd2147483647, 1'b1, n + 1 == total);
         for (int j = 0; j < dims; j++)
            for (int k = j; k < dims; k++, n++)
               push_entry(j, k, 1'b0, 64'sd2147483647, 1'b1, n + 1 == total);
         return;
      end
      sumsq = 0;
      for (int j = 0; j < 4; j++) mean_acc[j] = 0;
      for (int i = 0; i < stored_count; i++) begin
         wn = scaled_weight(weight_mem[i]);
         wc = (wn + 64'd32768) >> 16;
         sumsq += wc * wc;
         for (int j = 0; j < dims; j++)
            mean_acc[j] = add_saturated(mean_acc[j],
                                        longint'(wn) * longint'(vector_mem[i][j]));
      end
      divisor = longint'(64'd1 << 32) - longint'(sumsq);
      zero_div = divisor == 0;
      for (int j = 0; j < dims; j++, n++) begin
         acc = mean_acc[j];
         if (acc > 64'sh7FFFFFFFFFFFFFFF - 64'sd8388608) acc = 64'sh7FFFFFFFFFFFFFFF - 64'sd8388608;
         rounded = (acc + 64'sd8388608) >>> 24;
         centre[j] = rounded > 64'sd8388607 ? 64'sd8388607 :
                     (rounded < -64'sd8388608 ? -64'sd8388608 : rounded);
         push_entry(j, 0, 1'b1, clip32(rounded), zero_div, n + 1 == total);
      end
      for (int j = 0; j < dims; j++) begin
         for (int k = j; k < dims; k++, n++) begin
            acc = 0;
            for (int i = 0; i < stored_count; i++) begin
               wc = (scaled_weight(weight_mem[i]) + 64'd32768) >> 16;
               dj = longint'(vector_mem[i][j]) * 256 - centre[j];
               dk = longint'(vector_mem[i][k]) * 256 - centre[k];
               acc = add_saturated(acc, ((dj * dk) >>> 8) * longint'(wc));
            end
            if (zero_div) v = acc < 0 ? -64'sd2147483648 : 64'sd2147483647;
            else v = divide_covariance(acc, divisor);
            push_entry(j, k, 1'b0, v, zero_div, n + 1 == total);
         end
      end
   endfunction

   function automatic void load_particle(input particle_type p);
      if (stored_count < STORE_DEPTH) begin
         weight_mem[stored_count] = p.weight;
         for (int j = 0; j < 4; j++) vector_mem[stored_count][j] = p.state[j];
         model_weight_total += p.weight;
         stored_count++;
      end
      if (p.last) begin
         compute_set_statistics();
         stored_count = 0;
         model_weight_total = 0;
      end
   endfunction

   // Sender: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            load_particle(current);
            particles_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_particles.size() > 0) begin
               current = pending_particles.pop_front();
               req_weight <= current.weight;
               req_state_0 <= current.state[0];
               req_state_1 <= current.state[1];
               req_state_2 <= current.state[2];
               req_state_3 <= current.state[3];
               req_last <= current.last;
               req_valid <= 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls follow a randomly chosen, periodically redrawn pattern.
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= stall_cycle[0];
         2: rsp_ready <= $urandom_range(0, 9) < 7;
         default: rsp_ready <= (stall_cycle % 8) == 0;
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         stat_entry_type e;
         results_checked++;
         if (stats_expected.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            e = stats_expected.pop_front();
            if (rsp_row !== e.row || rsp_col !== e.col || rsp_is_mean !== e.is_mean)
               report_mismatch($sformatf("entry r%0d c%0d m%0d, expected r%0d c%0d m%0d",
                  rsp_row, rsp_col, rsp_is_mean, e.row, e.col, e.is_mean));
            if (rsp_value !== e.value)
               report_mismatch($sformatf("value %h, expected %h (r%0d c%0d m%0d)",
                  rsp_value, e.value, e.row, e.col, e.is_mean));
            if (rsp_degenerate !== e.degenerate)
               report_mismatch($sformatf("degenerate %b, expected %b",
                  rsp_degenerate, e.degenerate));
            if (rsp_end_of_run !== e.end_of_run)
               report_mismatch($sformatf("end_of_run %b, expected %b",
                  rsp_end_of_run, e.end_of_run));
         end
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_NORMALIZE) normalize_cfg = data[0];
      else if (addr == ADDR_DIMS) dims_cfg = data[2:0];
   endtask

   task automatic configure(input logic norm, input logic [2:0] dims);
      csr_write(ADDR_NORMALIZE, {31'd0, norm});
      csr_write(ADDR_DIMS, {29'd0, dims});
   endtask

   task automatic wait_idle();
      while (pending_particles.size() > 0 || req_valid || stats_expected.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void queue_particle(input logic [15:0] w, input logic [15:0] s0,
                                          input logic [15:0] s1, input logic [15:0] s2,
                                          input logic [15:0] s3, input logic last);
      particle_type p;
      p.weight = w;
      p.state[0] = s0;
      p.state[1] = s1;
      p.state[2] = s2;
      p.state[3] = s3;
      p.last = last;
      pending_particles.push_back(p);
   endfunction

   function automatic logic [15:0] random_state(input bit narrow);
      if (narrow) return 16'($signed($urandom_range(0, 2047)) - 1024);
      return 16'($urandom);
   endfunction

   function automatic void queue_random_set(input int size);
      logic [15:0] w;
      bit narrow;
      narrow = 1'($urandom_range(0, 1));
      for (int i = 0; i < size; i++) begin
         case ($urandom_range(0, 7))
            0: w = 16'd0;
            1: w = 16'hFFFF;
            2: w = 16'($urandom_range(0, 255));
            default: w = 16'($urandom);
         endcase
         queue_particle(w, random_state(narrow), random_state(narrow),
                        random_state(narrow), random_state(narrow), i == size - 1);
      end
   endfunction

   initial begin
      int items;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: normalize on, all four components.
      queue_particle(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
      queue_particle(16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
      queue_particle(16'h0000, 16'h0100, 16'hFF00, 16'h1234, 16'h0001, 1'b1);
      // A lone particle takes all the weight, so the divisor is zero.
      queue_particle(16'h1234, 16'h0300, 16'hFD00, 16'h7FFF, 16'h8000, 1'b1);
      // All weights zero while normalizing.
      queue_particle(16'h0000, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 1'b0);
      queue_particle(16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
      wait_idle();

      // Raw weights: large ones drive the divisor negative.
      configure(1'b0, 3'd2);
      queue_particle(16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0);
      queue_particle(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
      queue_particle(16'h4000, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 1'b0);
      queue_particle(16'h4000, 16'hFF00, 16'h0300, 16'h0000, 16'h0000, 1'b1);
      queue_particle(16'h0000, 16'h0500, 16'h0600, 16'h0000, 16'h0000, 1'b1);
      wait_idle();

      // Dimension counts outside the legal range are clamped.
      configure(1'b1, 3'd0);
      queue_particle(16'h8000, 16'h0A00, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_particle(16'h8000, 16'hF600, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      wait_idle();
      configure(1'b0, 3'd7);
      queue_particle(16'h2000, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 1'b0);
      queue_particle(16'h6000, 16'hFF00, 16'hFE00, 16'hFD00, 16'hFC00, 1'b1);
      wait_idle();

      items = 0;
      while (items < 85) begin
         configure(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
         for (int s = 0; s < 4; s++) begin
            int size;
            size = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
            queue_random_set(size);
            items += size;
         end
         wait_idle();
      end
      configure(1'b1, 3'd4);
      queue_random_set(4);
      wait_idle();
      repeat (200) @(posedge clock);

      $display("%0d particles in %0d sets, %0d result transfers checked, %0d mismatches",
               particles_sent, sets_done, results_checked, error_count);
      $display("covered raw and normalized weights, all dimension settings, ",
               "zero sums and zero and negative divisors");
      if (error_count == 0 && stats_expected.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/wpmc_pkg.sv
hdl/wpmc_div.sv
hdl/weighted_particle_mean_covariance_top.sv
test/testbench.sv
